// ===== rtl/core/vwts_pkg.sv =====
// ----------------------------------------------------------------------------
// vwts_pkg
// Shared widths, register indexes, event codes and types of the video window
// tracker and scaler.
// ----------------------------------------------------------------------------
package vwts_pkg;

	localparam int COORD_BITS = 13;
	localparam int CFG_BITS   = 13;
	localparam int THR_BITS   = 8;
	localparam int MODE_BITS  = 2;
	localparam int WIN_BITS   = 16;
	localparam int EV_BITS    = 2;
	localparam int IDX_BITS   = 3;

	// Scaled operand is a start coordinate plus the offset, so one bit wider.
	localparam int V_BITS       = COORD_BITS + 1;
	localparam int PROD_BITS    = V_BITS + CFG_BITS;
	localparam int CNT_BITS     = $clog2(PROD_BITS);
	localparam int START_OFFSET = 2;

	localparam logic [IDX_BITS-1:0] CFG_INPUT_WIDTH   = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] CFG_INPUT_HEIGHT  = IDX_BITS'(1);
	localparam logic [IDX_BITS-1:0] CFG_OUTPUT_WIDTH  = IDX_BITS'(2);
	localparam logic [IDX_BITS-1:0] CFG_OUTPUT_HEIGHT = IDX_BITS'(3);
	localparam logic [IDX_BITS-1:0] CFG_DEMO_MODE     = IDX_BITS'(4);
	localparam logic [IDX_BITS-1:0] CFG_CHANGE_THR    = IDX_BITS'(5);

	localparam logic [MODE_BITS-1:0] DEMO_RIGHT_HALF = MODE_BITS'(1);
	localparam logic [MODE_BITS-1:0] DEMO_LEFT_HALF  = MODE_BITS'(2);

	localparam logic [EV_BITS-1:0] EV_NONE  = EV_BITS'(0);
	localparam logic [EV_BITS-1:0] EV_APPLY = EV_BITS'(1);
	localparam logic [EV_BITS-1:0] EV_CLEAR = EV_BITS'(2);

	typedef struct packed {
		logic [CFG_BITS-1:0]  input_width;
		logic [CFG_BITS-1:0]  input_height;
		logic [CFG_BITS-1:0]  output_width;
		logic [CFG_BITS-1:0]  output_height;
		logic [MODE_BITS-1:0] demo_mode;
		logic [THR_BITS-1:0]  change_threshold;
	} vwts_cfg_t;

	typedef struct packed {
		logic                  found;
		logic [COORD_BITS-1:0] det_x_start;
		logic [COORD_BITS-1:0] det_x_end;
		logic [COORD_BITS-1:0] det_y_start;
		logic [COORD_BITS-1:0] det_y_end;
	} vwts_det_t;

	typedef struct packed {
		logic [EV_BITS-1:0]  event_res;
		logic [WIN_BITS-1:0] win_x_start;
		logic [WIN_BITS-1:0] win_y_start;
		logic [WIN_BITS-1:0] win_width;
		logic [WIN_BITS-1:0] win_height;
	} vwts_win_t;

	// Request to the serial scaling unit: round(v * num / den).
	typedef struct packed {
		logic                start;
		logic [V_BITS-1:0]   v;
		logic [CFG_BITS-1:0] num;
		logic [CFG_BITS-1:0] den;
	} vwts_scale_req_t;

	typedef struct packed {
		logic                done;
		logic [WIN_BITS-1:0] quotient;
	} vwts_scale_rsp_t;

endpackage

// ===== rtl/core/vwts_if.sv =====
// ----------------------------------------------------------------------------
// vwts_if
// Valid/ready channels of the video window tracker: detection reports in,
// window results out, and configuration register writes.
// ----------------------------------------------------------------------------
interface vwts_det_if import vwts_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic [COORD_BITS-1:0] det_x_start;
	logic [COORD_BITS-1:0] det_x_end;
	logic [COORD_BITS-1:0] det_y_start;
	logic [COORD_BITS-1:0] det_y_end;

	modport source (output valid, found, det_x_start, det_x_end, det_y_start, det_y_end,
		input ready);
	modport sink (input valid, found, det_x_start, det_x_end, det_y_start, det_y_end,
		output ready);
endinterface

interface vwts_win_if import vwts_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [EV_BITS-1:0]  event_res;
	logic [WIN_BITS-1:0] win_x_start;
	logic [WIN_BITS-1:0] win_y_start;
	logic [WIN_BITS-1:0] win_width;
	logic [WIN_BITS-1:0] win_height;

	modport source (output valid, event_res, win_x_start, win_y_start, win_width,
		win_height, input ready);
	modport sink (input valid, event_res, win_x_start, win_y_start, win_width,
		win_height, output ready);
endinterface

interface vwts_cfg_if import vwts_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [IDX_BITS-1:0] index;
	logic [CFG_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/vwts_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// vwts_cfg_regs
// Configuration register file; every write transfer is taken at once.
// ----------------------------------------------------------------------------
module vwts_cfg_regs import vwts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	vwts_cfg_if.sink   cfg,
	output vwts_cfg_t  regs
);

	vwts_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.input_width      <= CFG_BITS'(1920);
			regs_q.input_height     <= CFG_BITS'(1080);
			regs_q.output_width     <= CFG_BITS'(1920);
			regs_q.output_height    <= CFG_BITS'(1080);
			regs_q.demo_mode        <= '0;
			regs_q.change_threshold <= THR_BITS'(3);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_INPUT_WIDTH:   regs_q.input_width      <= cfg.data;
				CFG_INPUT_HEIGHT:  regs_q.input_height     <= cfg.data;
				CFG_OUTPUT_WIDTH:  regs_q.output_width     <= cfg.data;
				CFG_OUTPUT_HEIGHT: regs_q.output_height    <= cfg.data;
				CFG_DEMO_MODE:     regs_q.demo_mode        <= cfg.data[MODE_BITS-1:0];
				CFG_CHANGE_THR:    regs_q.change_threshold <= cfg.data[THR_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/vwts_scale_unit.sv =====
// ----------------------------------------------------------------------------
// vwts_scale_unit
// Bit-serial scaler: shift-and-add multiply, one multiplier bit per cycle,
// then a restoring divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vwts_scale_unit import vwts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  vwts_scale_req_t  req,
	output vwts_scale_rsp_t  rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV
	} state_t;

	state_t               state_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [PROD_BITS-1:0] acc_q;
	logic [PROD_BITS-1:0] mcand_q;
	logic [CFG_BITS-1:0]  mplier_q;
	logic [CFG_BITS-1:0]  den_q;
	logic [CFG_BITS-1:0]  rem_q;
	logic [WIN_BITS-1:0]  quo_q;
	logic                 done_q;

	logic [CFG_BITS:0] trial;
	logic [CFG_BITS:0] diff;
	logic              fits;

	// The dividend leaves the accumulator from its top bit downward.
	always_comb begin
		trial = {rem_q, acc_q[PROD_BITS-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.start) begin
						// Rounding term den/2 is preloaded into the product.
						acc_q    <= PROD_BITS'(req.den >> 1);
						mcand_q  <= PROD_BITS'(req.v);
						mplier_q <= req.num;
						den_q    <= req.den;
						cnt_q    <= '0;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					if (mplier_q[0]) begin
						acc_q <= acc_q + mcand_q;
					end
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					if (cnt_q == CNT_BITS'(CFG_BITS - 1)) begin
						cnt_q   <= '0;
						rem_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV: begin
					// A zero divisor always fits, which yields all ones.
					rem_q <= fits ? diff[CFG_BITS-1:0] : trial[CFG_BITS-1:0];
					quo_q <= {quo_q[WIN_BITS-2:0], fits};
					acc_q <= acc_q << 1;
					if (cnt_q == CNT_BITS'(PROD_BITS - 1)) begin
						cnt_q   <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/video_window_track_scale_core.sv =====
// ----------------------------------------------------------------------------
// video_window_track_scale_core
// Tracks the detected video window frame by frame and rescales it to the
// output raster, giving apply and clear events.
// ----------------------------------------------------------------------------
// Usage: one detection report per frame is transferred on det; exactly one
// result is transferred on win for each report. Registers are written on cfg
// while the block is idle; every write transfer is accepted at once.
// A report that neither clears nor moves the window passes through T_EVAL,
// which registers its result, and T_POST, which loads the output register.
// A moved window goes through four rounded scalings on one shared
// bit-serial unit, each a start, 13 multiply steps, 27 divide steps and a
// hand-back.
// One report is worked on at a time; det.ready is high while the tracker
// waits for a report. A finished result sits in the output register while
// the next report is taken; only if that next result is finished while the
// receiver still stalls does the tracker hold it until win.ready.
// Reset clears the stored window and the found history and loads the
// register defaults (1920 by 1080 both sides, full mode, threshold 3).
// ----------------------------------------------------------------------------
module video_window_track_scale_core import vwts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	vwts_det_if.sink  det,
	vwts_win_if.source win,
	vwts_cfg_if.sink  cfg
);

	typedef enum logic [2:0] {
		T_IDLE,
		T_EVAL,
		T_START,
		T_WAIT,
		T_CALC,
		T_POST
	} state_t;

	vwts_cfg_t        regs;
	vwts_scale_req_t  sreq;
	vwts_scale_rsp_t  srsp;

	state_t                state_q;
	vwts_det_t             det_q;
	logic                  was_found_q;
	logic [COORD_BITS-1:0] st_xs_q;
	logic [COORD_BITS-1:0] st_xe_q;
	logic [COORD_BITS-1:0] st_ys_q;
	logic [COORD_BITS-1:0] st_ye_q;
	logic [1:0]            op_q;
	logic [WIN_BITS-1:0]   qres_q [4];
	vwts_win_t             res_q;
	vwts_win_t             out_q;
	logic                  out_valid_q;

	logic                moved_any;
	logic [WIN_BITS-1:0] calc_w;
	logic [WIN_BITS-1:0] calc_h;
	vwts_win_t           calc_res;

	// A coordinate counts as moved when it is further than the threshold away.
	function automatic logic moved(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b, input logic [THR_BITS-1:0] thr);
		logic [COORD_BITS-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return d > COORD_BITS'(thr);
	endfunction

	vwts_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	vwts_scale_unit u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.rsp    (srsp)
	);

	assign det.ready = (state_q == T_IDLE);

	assign win.valid       = out_valid_q;
	assign win.event_res   = out_q.event_res;
	assign win.win_x_start = out_q.win_x_start;
	assign win.win_y_start = out_q.win_y_start;
	assign win.win_width   = out_q.win_width;
	assign win.win_height  = out_q.win_height;

	always_comb begin
		moved_any = moved(det_q.det_x_start, st_xs_q, regs.change_threshold)
			|| moved(det_q.det_x_end, st_xe_q, regs.change_threshold)
			|| moved(det_q.det_y_start, st_ys_q, regs.change_threshold)
			|| moved(det_q.det_y_end, st_ye_q, regs.change_threshold);
	end

	// The four scalings run in order: x start, x end, y start, y end.
	// Start coordinates carry the fixed offset before they are scaled.
	always_comb begin
		sreq.start = (state_q == T_START);
		unique case (op_q)
			2'd0: begin
				sreq.v   = V_BITS'(st_xs_q) + V_BITS'(START_OFFSET);
				sreq.num = regs.output_width;
				sreq.den = regs.input_width;
			end
			2'd1: begin
				sreq.v   = V_BITS'(st_xe_q);
				sreq.num = regs.output_width;
				sreq.den = regs.input_width;
			end
			2'd2: begin
				sreq.v   = V_BITS'(st_ys_q) + V_BITS'(START_OFFSET);
				sreq.num = regs.output_height;
				sreq.den = regs.input_height;
			end
			default: begin
				sreq.v   = V_BITS'(st_ye_q);
				sreq.num = regs.output_height;
				sreq.den = regs.input_height;
			end
		endcase
	end

	// Sizes wrap at 16 bits; an empty window gives no event and zero fields.
	// The half modes keep the right or the left half of the window.
	always_comb begin
		calc_w   = qres_q[1] - qres_q[0];
		calc_h   = qres_q[3] - qres_q[2];
		calc_res = '0;
		if (calc_w != '0 && calc_h != '0) begin
			calc_res.event_res   = EV_APPLY;
			calc_res.win_x_start = qres_q[0];
			calc_res.win_y_start = qres_q[2];
			calc_res.win_width   = calc_w;
			calc_res.win_height  = calc_h;
			if (regs.demo_mode == DEMO_RIGHT_HALF) begin
				calc_res.win_x_start = qres_q[0] + (calc_w >> 1);
				calc_res.win_width   = calc_w >> 1;
			end else if (regs.demo_mode == DEMO_LEFT_HALF) begin
				calc_res.win_width = calc_w >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			was_found_q <= 1'b0;
			st_xs_q     <= '0;
			st_xe_q     <= '0;
			st_ys_q     <= '0;
			st_ye_q     <= '0;
			op_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// In T_POST the output register is either reloaded or kept.
			if (win.ready && state_q != T_POST) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (det.valid) begin
						det_q.found       <= det.found;
						det_q.det_x_start <= det.det_x_start;
						det_q.det_x_end   <= det.det_x_end;
						det_q.det_y_start <= det.det_y_start;
						det_q.det_y_end   <= det.det_y_end;
						state_q           <= T_EVAL;
					end
				end
				T_EVAL: begin
					was_found_q <= det_q.found;
					if (!det_q.found) begin
						// Losing a tracked window clears it and reports so.
						res_q <= {(was_found_q ? EV_CLEAR : EV_NONE),
							{(4 * WIN_BITS){1'b0}}};
						if (was_found_q) begin
							st_xs_q <= '0;
							st_xe_q <= '0;
							st_ys_q <= '0;
							st_ye_q <= '0;
						end
						state_q <= T_POST;
					end else if (moved_any) begin
						st_xs_q <= det_q.det_x_start;
						st_xe_q <= det_q.det_x_end;
						st_ys_q <= det_q.det_y_start;
						st_ye_q <= det_q.det_y_end;
						op_q    <= '0;
						state_q <= T_START;
					end else begin
						res_q   <= '0;
						state_q <= T_POST;
					end
				end
				T_START: begin
					state_q <= T_WAIT;
				end
				T_WAIT: begin
					if (srsp.done) begin
						qres_q[op_q] <= srsp.quotient;
						op_q         <= op_q + 1'b1;
						state_q      <= (op_q == 2'd3) ? T_CALC : T_START;
					end
				end
				T_CALC: begin
					res_q   <= calc_res;
					state_q <= T_POST;
				end
				T_POST: begin
					if (!out_valid_q || win.ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

endmodule
